>>> rtl/buddy_allocator_core_macros.svh
// Assertion macros for the buddy allocator core.
`ifndef BUDDY_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BUDDY_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("buddy allocator check failed");
`define BUDDY_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator sequence check failed");
`else
`define BUDDY_ASSERT(lbl, clk, rst_n, prop)
`define BUDDY_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/buddy_pkg.sv
// Shared types, constants and helpers of the buddy allocator.
package buddy_pkg;

    localparam int BUDDY_POOL_UNITS = 1024;
    localparam int REQ_W            = 16;
    localparam int OFF_OUT_W        = 10;
    localparam int STATUS_W         = 2;
    localparam int LOG_W            = $clog2(REQ_W + 1);

    typedef enum logic [STATUS_W-1:0] {
        RES_OK         = 2'd0,
        RES_NO_SPACE   = 2'd1,
        RES_BAD_OFFSET = 2'd2,
        RES_NOT_ALLOC  = 2'd3
    } t_res;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_CHECK,
        OP_DOWN,
        OP_MARK,
        OP_AUP,
        OP_FIND,
        OP_FUP,
        OP_RESP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic fail;
        logic is_free;
        logic hit;
        logic zero;
        logic top;
        logic out_free;
    } t_dp_sts;

    // Exponent of the request rounded up to a power of two; zero and one give zero.
    function automatic logic [LOG_W-1:0] f_ceil_log2(input logic [REQ_W-1:0] v);
        logic [REQ_W-1:0] m;
        logic [LOG_W-1:0] r;
        m = (v == '0) ? '0 : v - 1'b1;
        r = '0;
        for (int k = 0; k < REQ_W; k++) begin
            if (m[k]) begin
                r = LOG_W'(k + 1);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/buddy_if.sv
// Request and response channel interfaces of the buddy allocator.
interface buddy_req_if import buddy_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [REQ_W-1:0] request_units;
    logic [REQ_W-1:0] release_offset;

    modport source (output valid, action, request_units, release_offset, input ready);
    modport sink   (input valid, action, request_units, release_offset, output ready);
endinterface

interface buddy_rsp_if import buddy_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OFF_OUT_W-1:0] block_offset;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, block_offset, status, input ready);
    modport sink   (input valid, block_offset, status, output ready);
endinterface

>>> rtl/buddy_ctrl.sv
// Sequencer of the buddy allocator: clear pass, walk down, walk up, response.
module buddy_ctrl import buddy_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_CHECK = 9'b000000100,
        ST_DOWN  = 9'b000001000,
        ST_MARK  = 9'b000010000,
        ST_AUP   = 9'b000100000,
        ST_FIND  = 9'b001000000,
        ST_FUP   = 9'b010000000,
        ST_RESP  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_IDLE;
        o_cmd.load = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.op   = OP_IDLE;
                o_cmd.load = i_req_valid;
                if (i_req_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.op = OP_CHECK;
                if (i_sts.fail) begin
                    n_state = ST_RESP;
                end else if (i_sts.is_free) begin
                    n_state = ST_FIND;
                end else if (i_sts.hit) begin
                    n_state = ST_MARK;
                end else begin
                    n_state = ST_DOWN;
                end
            end
            ST_DOWN: begin
                o_cmd.op = OP_DOWN;
                if (i_sts.hit) begin
                    n_state = ST_MARK;
                end
            end
            ST_MARK: begin
                o_cmd.op = OP_MARK;
                n_state  = i_sts.top ? ST_RESP : ST_AUP;
            end
            ST_AUP: begin
                o_cmd.op = OP_AUP;
                if (i_sts.top) begin
                    n_state = ST_RESP;
                end
            end
            ST_FIND: begin
                o_cmd.op = OP_FIND;
                if (i_sts.top) begin
                    n_state = ST_RESP;
                end else if (i_sts.zero) begin
                    n_state = ST_FUP;
                end
            end
            ST_FUP: begin
                o_cmd.op = OP_FUP;
                if (i_sts.top) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                o_cmd.op = OP_RESP;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/buddy_dp.sv
// Datapath of the buddy allocator: free-size tree memory, walk registers, response register.
module buddy_dp import buddy_pkg::*; #(
    parameter int POOL_UNITS = BUDDY_POOL_UNITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_action,
    input  logic [REQ_W-1:0]     i_request_units,
    input  logic [REQ_W-1:0]     i_release_offset,
    input  logic                 i_rsp_ready,
    output logic                 o_rsp_valid,
    output logic [OFF_OUT_W-1:0] o_block_offset,
    output logic [STATUS_W-1:0]  o_status
);

    localparam int LOG_P = $clog2(POOL_UNITS);
    localparam int NODES = 2 * POOL_UNITS - 1;
    localparam int IW    = LOG_P + 1;
    localparam int VW    = LOG_P + 1;
    localparam int OW    = LOG_P;

    localparam logic [IW-1:0]    LAST_NODE = IW'(NODES - 1);
    localparam logic [IW-1:0]    LEAF_BASE = IW'(POOL_UNITS - 1);
    localparam logic [LOG_W-1:0] LOG_P_L   = LOG_W'(LOG_P);

    // Largest free block under each node; root at index 0, children at 2i+1 and 2i+2.
    logic [VW-1:0] r_tree [NODES];
    logic [VW-1:0] r_rd_a;
    logic [VW-1:0] r_rd_b;

    logic                 r_action;
    logic [LOG_W-1:0]     r_want_log;
    logic                 r_bad_off;
    logic [IW-1:0]        r_node;
    logic [LOG_W-1:0]     r_slog;
    logic [OW-1:0]        r_offset;
    logic [VW-1:0]        r_val;
    t_res                 r_res_status;
    logic [OW-1:0]        r_res_offset;
    logic                 r_rsp_valid;
    logic [OFF_OUT_W-1:0] r_rsp_offset;
    t_res                 r_rsp_status;
    logic [IW-1:0]        r_clr_idx;
    logic [LOG_W-1:0]     r_clr_slog;
    logic [IW-1:0]        r_clr_end;

    logic [VW-1:0]    want;
    logic             too_big;
    logic [IW-1:0]    lchild;
    logic             go_right;
    logic [IW-1:0]    dn_node;
    logic [IW-1:0]    dn_lchild;
    logic [LOG_W-1:0] dn_slog;
    logic [IW-1:0]    par;
    logic [IW-1:0]    node_sib;
    logic [IW-1:0]    par_sib;
    logic [LOG_W-1:0] up_slog;
    logic [VW-1:0]    up_span;
    logic [VW-1:0]    find_span;
    logic [VW-1:0]    amax;
    logic [VW:0]      pair_sum;
    logic [VW-1:0]    fup_val;
    logic             rd_zero;
    logic             out_free;
    logic [IW-1:0]    leaf;

    logic          we;
    logic [IW-1:0] wa;
    logic [VW-1:0] wd;
    logic [IW-1:0] addr_a;
    logic [IW-1:0] addr_b;

    assign want      = VW'(1) << r_want_log;
    assign too_big   = (r_want_log > LOG_P_L) || (r_rd_a < want);
    assign lchild    = {r_node[IW-2:0], 1'b1};
    // Best fit: take the smaller child whenever it still holds the request.
    assign go_right  = (r_rd_a > r_rd_b) ? (r_rd_b >= want) : (r_rd_a < want);
    assign dn_node   = go_right ? lchild + IW'(1) : lchild;
    assign dn_lchild = {dn_node[IW-2:0], 1'b1};
    assign dn_slog   = r_slog - LOG_W'(1);
    assign par       = IW'((r_node - IW'(1)) >> 1);
    assign node_sib  = r_node[0] ? r_node + IW'(1) : r_node - IW'(1);
    assign par_sib   = par[0] ? par + IW'(1) : par - IW'(1);
    assign up_slog   = r_slog + LOG_W'(1);
    assign up_span   = VW'(1) << up_slog;
    assign find_span = VW'(1) << r_slog;
    assign amax      = (r_val > r_rd_a) ? r_val : r_rd_a;
    assign pair_sum  = {1'b0, r_val} + {1'b0, r_rd_a};
    // Merge two wholly free buddies into one block of the parent's size.
    assign fup_val   = (pair_sum == {1'b0, up_span}) ? up_span : amax;
    assign rd_zero   = (r_rd_a == '0);
    assign out_free  = !r_rsp_valid || i_rsp_ready;
    assign leaf      = IW'(i_release_offset[LOG_P-1:0]) + LEAF_BASE;

    assign o_sts.clr_last = (r_clr_idx == LAST_NODE);
    assign o_sts.fail     = r_action ? r_bad_off : too_big;
    assign o_sts.is_free  = r_action;
    assign o_sts.hit      = (i_cmd.op == OP_DOWN) ? (dn_slog == r_want_log)
                                                  : (r_slog == r_want_log);
    assign o_sts.zero     = rd_zero;
    assign o_sts.top      = ((i_cmd.op == OP_AUP) || (i_cmd.op == OP_FUP)) ? (par == '0)
                                                                         : (r_node == '0);
    assign o_sts.out_free = out_free;

    always_comb begin
        we     = 1'b0;
        wa     = '0;
        wd     = '0;
        addr_a = '0;
        addr_b = '0;
        case (i_cmd.op)
            OP_CLEAR: begin
                we = 1'b1;
                wa = r_clr_idx;
                wd = VW'(1) << r_clr_slog;
            end
            OP_CHECK: begin
                if (r_action) begin
                    addr_a = r_node;
                end else begin
                    addr_a = lchild;
                    addr_b = lchild + IW'(1);
                end
            end
            OP_DOWN: begin
                addr_a = dn_lchild;
                addr_b = dn_lchild + IW'(1);
            end
            OP_MARK: begin
                we     = 1'b1;
                wa     = r_node;
                addr_a = node_sib;
            end
            OP_AUP: begin
                we     = 1'b1;
                wa     = par;
                wd     = amax;
                addr_a = par_sib;
            end
            OP_FIND: begin
                if (rd_zero) begin
                    we     = 1'b1;
                    wa     = r_node;
                    wd     = find_span;
                    addr_a = node_sib;
                end else begin
                    addr_a = par;
                end
            end
            OP_FUP: begin
                we     = 1'b1;
                wa     = par;
                wd     = fup_val;
                addr_a = par_sib;
            end
            default: begin
                addr_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_tree[wa] <= wd;
        end
        r_rd_a <= r_tree[addr_a];
        r_rd_b <= r_tree[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= i_action;
            r_want_log <= f_ceil_log2(i_request_units);
            r_bad_off  <= (32'(i_release_offset) >= 32'(POOL_UNITS));
            r_node     <= i_action ? leaf : '0;
            r_slog     <= i_action ? '0 : LOG_P_L;
            r_offset   <= '0;
        end
        case (i_cmd.op)
            OP_CHECK: begin
                if (o_sts.fail) begin
                    r_res_status <= r_action ? RES_BAD_OFFSET : RES_NO_SPACE;
                    r_res_offset <= '0;
                end
            end
            OP_DOWN: begin
                r_node <= dn_node;
                r_slog <= dn_slog;
                if (go_right) begin
                    r_offset <= r_offset + (OW'(1) << dn_slog);
                end
            end
            OP_MARK: begin
                r_val        <= '0;
                r_res_status <= RES_OK;
                r_res_offset <= r_offset;
            end
            OP_AUP: begin
                r_node <= par;
                r_val  <= amax;
            end
            OP_FIND: begin
                r_res_offset <= '0;
                if (rd_zero) begin
                    r_val        <= find_span;
                    r_res_status <= RES_OK;
                end else begin
                    r_res_status <= RES_NOT_ALLOC;
                    r_node       <= par;
                    r_slog       <= up_slog;
                end
            end
            OP_FUP: begin
                r_node <= par;
                r_slog <= up_slog;
                r_val  <= fup_val;
            end
            default: begin
                r_val <= r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clr_slog <= LOG_P_L;
            r_clr_end  <= '0;
        end else if (i_cmd.op == OP_CLEAR) begin
            r_clr_idx <= r_clr_idx + IW'(1);
            // Each tree level ends at index 2^k - 2; halve the span past it.
            if (r_clr_idx == r_clr_end) begin
                r_clr_slog <= r_clr_slog - LOG_W'(1);
                r_clr_end  <= {r_clr_end[IW-2:0], 1'b0} + IW'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if ((i_cmd.op == OP_RESP) && out_free) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == OP_RESP) && out_free) begin
            r_rsp_offset <= OFF_OUT_W'(r_res_offset);
            r_rsp_status <= r_res_status;
        end
    end

    assign o_rsp_valid    = r_rsp_valid;
    assign o_block_offset = r_rsp_offset;
    assign o_status       = r_rsp_status;

endmodule

>>> rtl/buddy_allocator_core.sv
// Top level of the buddy allocator core.
// A binary buddy allocator over POOL_UNITS units. Requests arrive on i_req
// (valid/ready): action 0 allocates request_units rounded up to a power of
// two, action 1 frees the block holding release_offset. Each request gives
// exactly one response on o_rsp: block_offset and status (ok, no space,
// offset out of range, offset not allocated).
// One request is worked on at a time. An allocate walks down the tree
// level by level, reading both children through the two read ports of
// the tree memory, then walks level by level back up to refresh the
// ancestors. A free walks up the same way, to the used node and then up to
// the root. Rejected requests go from the check straight to the response.
// After reset the tree memory is cleared to the empty pool in one pass over
// all 2*POOL_UNITS - 1 nodes; i_req.ready stays low until it is done.
// The response is held in an output register; a new request is taken while
// it waits, and a finished walk holds in place until the register is free.
`include "buddy_allocator_core_macros.svh"

module buddy_allocator_core import buddy_pkg::*; #(
    parameter int POOL_UNITS = BUDDY_POOL_UNITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    buddy_req_if.sink   i_req,
    buddy_rsp_if.source o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    buddy_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    buddy_dp #(
        .POOL_UNITS (POOL_UNITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_action         (i_req.action),
        .i_request_units  (i_req.request_units),
        .i_release_offset (i_req.release_offset),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_valid      (o_rsp.valid),
        .o_block_offset   (o_rsp.block_offset),
        .o_status         (o_rsp.status)
    );

    `BUDDY_ASSERT_NEXT(a_accept_checks, i_clk, i_rst_n, i_req.valid && i_req.ready, w_cmd.op == OP_CHECK)
    `BUDDY_ASSERT(a_rsp_from_resp, i_clk, i_rst_n, $rose(o_rsp.valid) |-> $past(w_cmd.op == OP_RESP))
    `BUDDY_ASSERT(a_ready_origin, i_clk, i_rst_n, $rose(i_req.ready) |-> $past(w_cmd.op == OP_CLEAR) || $past(w_cmd.op == OP_RESP))

endmodule

>>> tb/sv/buddy_tb_pkg.sv
// Request codes shared by the buddy allocator testbench modules.
package buddy_tb_pkg;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

endpackage

>>> tb/sv/buddy_allocator_core_check.sv
// Checker of the buddy allocator: predicts every response from the accepted requests.
module buddy_allocator_core_check import buddy_pkg::*, buddy_tb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    buddy_req_if  i_req,
    buddy_rsp_if  i_rsp,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNITS = BUDDY_POOL_UNITS;
    localparam int NODES = 2 * UNITS - 1;

    typedef struct packed {
        logic [OFF_OUT_W-1:0] offset;
        t_res                 status;
    } t_grant;

    // Largest free block under each node; node 0 is the root, children 2i+1 and 2i+2.
    logic [10:0] largest_free [NODES];
    t_grant      grant_q [$];
    t_grant      oldest;
    int          init_span;

    function automatic t_grant predict_alloc(input logic [REQ_W-1:0] units);
        int     want;
        int     span;
        int     node;
        int     lo_child;
        int     hi_child;
        int     swap;
        t_grant g;
        want = 1;
        span = UNITS;
        node = 0;
        g    = '{offset: '0, status: RES_NO_SPACE};
        while (want < ((units == '0) ? 1 : int'(units))) begin
            want <<= 1;
        end
        if (int'(largest_free[0]) < want) begin
            return g;
        end
        // Best fit: descend into the child with the smaller block that still fits.
        while (span != want) begin
            lo_child = 2 * node + 1;
            hi_child = 2 * node + 2;
            if (largest_free[lo_child] > largest_free[hi_child]) begin
                swap     = lo_child;
                lo_child = hi_child;
                hi_child = swap;
            end
            node = (int'(largest_free[lo_child]) >= want) ? lo_child : hi_child;
            span >>= 1;
        end
        largest_free[node] = '0;
        g.offset = OFF_OUT_W'((node + 1) * span - UNITS);
        g.status = RES_OK;
        while (node != 0) begin
            node = (node - 1) >> 1;
            largest_free[node] = (largest_free[2*node+1] > largest_free[2*node+2]) ?
                                 largest_free[2*node+1] : largest_free[2*node+2];
        end
        return g;
    endfunction

    function automatic t_grant predict_free(input logic [REQ_W-1:0] release_offset);
        int     span;
        int     node;
        int     lsum;
        t_grant g;
        g = '{offset: '0, status: RES_BAD_OFFSET};
        if (int'(release_offset) >= UNITS) begin
            return g;
        end
        span = 1;
        node = int'(release_offset) + UNITS - 1;
        // Climb to the used node that holds this offset.
        while (largest_free[node] != '0) begin
            if (node == 0) begin
                g.status = RES_NOT_ALLOC;
                return g;
            end
            span <<= 1;
            node = (node - 1) >> 1;
        end
        largest_free[node] = 11'(span);
        // Merge buddies on the way up.
        while (node != 0) begin
            node = (node - 1) >> 1;
            span <<= 1;
            lsum = int'(largest_free[2*node+1]) + int'(largest_free[2*node+2]);
            if (lsum == span) begin
                largest_free[node] = 11'(span);
            end else begin
                largest_free[node] = (largest_free[2*node+1] > largest_free[2*node+2]) ?
                                     largest_free[2*node+1] : largest_free[2*node+2];
            end
        end
        g.status = RES_OK;
        return g;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            init_span = 2 * UNITS;
            for (int i = 0; i < NODES; i++) begin
                if (((i + 1) & i) == 0) begin
                    init_span >>= 1;
                end
                largest_free[i] = 11'(init_span);
            end
            grant_q.delete();
        end else begin
            // Compare before taking a new request: a response never belongs to it.
            if (i_rsp.valid && i_rsp.ready) begin
                if (grant_q.size() == 0) begin
                    $error("response with no request outstanding: block_offset %0d status %0d",
                           i_rsp.block_offset, i_rsp.status);
                    o_fail_count++;
                end else begin
                    oldest = grant_q.pop_front();
                    if (i_rsp.block_offset !== oldest.offset) begin
                        $error("block_offset mismatch: expected %0d, actual %0d",
                               oldest.offset, i_rsp.block_offset);
                        o_fail_count++;
                    end
                    if (i_rsp.status !== oldest.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest.status, i_rsp.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.action == ACT_FREE) begin
                    grant_q.push_back(predict_free(i_req.release_offset));
                end else begin
                    grant_q.push_back(predict_alloc(i_req.request_units));
                end
            end
        end
        o_pending = grant_q.size();
    end

endmodule

>>> tb/sv/buddy_allocator_core_test.sv
// Top of the buddy allocator testbench: clock, reset, request stimulus and verdict.
module buddy_allocator_core_test import buddy_pkg::*, buddy_tb_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS  = 1300;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 40;

    typedef struct {
        logic             act;
        logic [REQ_W-1:0] units;
    } t_issued;

    typedef struct {
        logic [REQ_W-1:0] base;
        int               span;
    } t_block;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    int      fail_count;
    int      pending_results;
    t_issued issued_q [$];
    t_block  live_q [$];
    t_issued done_req;
    t_block  granted;
    int      n_alloc_ok, n_no_space, n_free_ok, n_bad_offset, n_not_alloc;
    int      hold_left;
    int      rsp_seen;
    bit      long_hold_done;

    buddy_req_if req_ch ();
    buddy_rsp_if rsp_ch ();

    buddy_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    buddy_allocator_core_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offer one request and hold it until it is taken.
    task automatic send_request(input logic act, input logic [REQ_W-1:0] units,
                                input logic [REQ_W-1:0] release_offset, input bit steady);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.action         <= act;
        req_ch.request_units  <= units;
        req_ch.release_offset <= release_offset;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Track granted blocks so that frees can aim at live allocations.
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready && issued_q.size() != 0) begin
            done_req = issued_q.pop_front();
            if (done_req.act == ACT_FREE) begin
                case (t_res'(rsp_ch.status))
                    RES_OK:         n_free_ok++;
                    RES_BAD_OFFSET: n_bad_offset++;
                    RES_NOT_ALLOC:  n_not_alloc++;
                    default: ;
                endcase
            end else if (t_res'(rsp_ch.status) == RES_OK) begin
                n_alloc_ok++;
                granted.base = REQ_W'(rsp_ch.block_offset);
                granted.span = 1;
                while (granted.span < int'(done_req.units)) granted.span <<= 1;
                live_q.push_back(granted);
            end else begin
                n_no_space++;
            end
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            issued_q.push_back('{req_ch.action, req_ch.request_units});
        end
    end

    // Response side: random stalls, one long hold-off, and a quiet window.
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
        end
        if (!long_hold_done && rsp_seen >= 300) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (!(rsp_seen >= 900 && rsp_seen < 1000) && $urandom_range(0, 3) == 0) begin
                hold_left = pick_gap();
            end
        end
    end

    initial begin
        int               idx;
        int               roll;
        bit               steady;
        logic [REQ_W-1:0] units;
        logic [REQ_W-1:0] off;
        t_block           blk;

        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.action         = ACT_ALLOC;
        req_ch.request_units  = '0;
        req_ch.release_offset = '0;
        rsp_ch.ready          = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero and odd sizes, the full pool, oversize, bad and unallocated frees.
        send_request(ACT_ALLOC, 16'd0,      16'hFFFF, 1'b0);
        send_request(ACT_ALLOC, 16'd1,      16'h0000, 1'b0);
        send_request(ACT_ALLOC, 16'd3,      16'h0000, 1'b0);
        send_request(ACT_ALLOC, 16'd1024,   16'h0000, 1'b0);
        send_request(ACT_ALLOC, 16'hFFFF,   16'h0000, 1'b0);
        send_request(ACT_ALLOC, 16'h8000,   16'h0000, 1'b0);
        send_request(ACT_FREE,  16'hFFFF,   16'd1023, 1'b0);
        send_request(ACT_FREE,  16'h0000,   16'd1024, 1'b0);
        send_request(ACT_FREE,  16'h0000,   16'hFFFF, 1'b0);
        send_request(ACT_FREE,  16'h0000,   16'd5,    1'b0);
        send_request(ACT_FREE,  16'h0000,   16'd0,    1'b0);
        send_request(ACT_FREE,  16'h0000,   16'd1,    1'b0);
        send_request(ACT_FREE,  16'h0000,   16'd0,    1'b0);
        send_request(ACT_ALLOC, 16'd1024,   16'h0000, 1'b1);
        send_request(ACT_ALLOC, 16'd1,      16'h0000, 1'b1);
        send_request(ACT_FREE,  16'h0000,   16'd512,  1'b1);
        send_request(ACT_ALLOC, 16'd512,    16'h0000, 1'b0);
        send_request(ACT_ALLOC, 16'd257,    16'h0000, 1'b0);
        send_request(ACT_ALLOC, 16'd0,      16'h0000, 1'b0);
        send_request(ACT_FREE,  16'h0000,   16'd512,  1'b0);
        send_request(ACT_FREE,  16'h0000,   16'd0,    1'b0);
        send_request(ACT_ALLOC, 16'd1025,   16'h0000, 1'b0);
        send_request(ACT_FREE,  16'h0000,   16'd1023, 1'b0);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            // Drain the block completely once in the middle of the run.
            if (i == 700) begin
                req_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending_results != 0);
            end
            steady = (i >= 400 && i < 520);
            if ($urandom_range(0, 99) < ((live_q.size() < 40) ? 65 : 40)) begin
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    units = REQ_W'($urandom_range(0, 4));
                end else if (roll < 85) begin
                    units = REQ_W'($urandom_range(5, 64));
                end else if (roll < 97) begin
                    units = REQ_W'($urandom_range(65, BUDDY_POOL_UNITS));
                end else begin
                    units = REQ_W'($urandom_range(0, 16'hFFFF));
                end
                send_request(ACT_ALLOC, units, REQ_W'($urandom()), steady);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70 && live_q.size() != 0) begin
                    idx = $urandom_range(0, live_q.size() - 1);
                    blk = live_q[idx];
                    live_q.delete(idx);
                    off = blk.base;
                    // Sometimes release by an offset that lies within the block.
                    if (roll < 12 && blk.span > 1) begin
                        off = off + REQ_W'($urandom_range(1, blk.span - 1));
                    end
                end else if (roll < 88) begin
                    off = REQ_W'($urandom_range(0, BUDDY_POOL_UNITS - 1));
                end else begin
                    off = REQ_W'($urandom_range(0, 16'hFFFF));
                end
                send_request(ACT_FREE, REQ_W'($urandom()), off, steady);
            end
        end

        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d allocations granted and %0d refused for lack of space.",
                 n_alloc_ok, n_no_space);
        $display("Frees: %0d released, %0d out of range, %0d of unallocated offsets.",
                 n_free_ok, n_bad_offset, n_not_alloc);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
